// File: hdl/assert_macros.svh
// Assertion macros for the stepper profile block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPSP_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SPSP_ASSERT(label, prop, msg)
`define SPSP_NEVER(label, expr, msg)
`endif
`endif

// File: hdl/spsp_pkg.sv
package spsp_pkg;

    // Register reset values and profile constants
    localparam logic [15:0] STEP_CONST_RST = 16'd12000;
    localparam logic [14:0] SPEED_LIM_RST  = 15'd6000;
    localparam logic [7:0]  SPEED_STEP_RST = 8'd10;
    localparam logic [9:0]  MS_PER_SEC     = 10'd1000;
    localparam logic [3:0]  LAST_SECOND    = 4'd11;
    localparam logic [16:0] STEP_COUNT_MAX = 17'h1FFFF;
    localparam int          DIV_BITS       = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STEP_CONST = 2'd0,
        CFG_SPEED_LIM  = 2'd1,
        CFG_SPEED_STEP = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACC_PLUS,
        ACC_ZERO,
        ACC_MINUS
    } accel_t;

    // Sequencer branch conditions
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_FETCH,
        COND_LOOP_DIV,
        COND_EMIT
    } cond_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_FETCH  = 3'd0;
    localparam upc_t UPC_LOAD   = 3'd1;
    localparam upc_t UPC_DIV    = 3'd2;
    localparam upc_t UPC_COMMIT = 3'd3;
    localparam upc_t UPC_EMIT   = 3'd4;

    // Control word fields that drive the datapath
    typedef struct packed {
        logic fetch;
        logic load;
        logic iter;
        logic commit;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        upc_t  target;
    } rom_word_t;

    // Microprogram
    function automatic rom_word_t rom_word(input upc_t upc);
        rom_word_t w;
        w = '{ctrl: '0, cond: COND_EMIT, target: UPC_FETCH};
        unique case (upc)
            UPC_FETCH:
            begin
                w.ctrl.fetch = 1'b1;
                w.cond       = COND_FETCH;
                w.target     = UPC_EMIT;
            end
            UPC_LOAD:
            begin
                w.ctrl.load = 1'b1;
                w.cond      = COND_NEXT;
            end
            UPC_DIV:
            begin
                w.ctrl.iter = 1'b1;
                w.cond      = COND_LOOP_DIV;
            end
            UPC_COMMIT:
            begin
                w.ctrl.commit = 1'b1;
                w.cond        = COND_NEXT;
            end
            UPC_EMIT:
            begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_EMIT;
                w.target    = UPC_FETCH;
            end
            default:
            begin
                w.cond   = COND_EMIT;
                w.target = UPC_FETCH;
            end
        endcase
        return w;
    endfunction

    // Acceleration by second of the profile
    function automatic accel_t accel_of(input logic [3:0] sec);
        accel_t a;
        if (sec > 4'd6 && sec < 4'd10)
            a = ACC_ZERO;
        else if (sec > 4'd2 && sec < 4'd6)
            a = ACC_MINUS;
        else
            a = ACC_PLUS;
        return a;
    endfunction

    // Full-step coil drive by phase
    function automatic logic [3:0] coil_of(input logic [1:0] ph);
        logic [3:0] c;
        case (ph)
            2'd0:    c = 4'b0011;
            2'd1:    c = 4'b0110;
            2'd2:    c = 4'b1100;
            default: c = 4'b1001;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/stepper_phase_speed_profile.sv
// A tick=1 transfer passes the load, divide loop, commit and emit states before its
// result shows; a tick=0 transfer goes from fetch straight to emit. One item is in work at a time.
// A tick=1 item runs the 16-iteration divider loop of the microprogram; emit waits
// while a stalled result still holds the output.
// Reset (rst_n, async low): registers to defaults, speed 1, counters and phase 0.
`include "assert_macros.svh"

module stepper_phase_speed_profile (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               tick,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         coil_pattern,
    output logic [1:0]         phase_index,
    output logic signed [15:0] speed_now,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import spsp_pkg::*;

    ctrl_t              ctrl;
    logic               div_last;
    logic               out_free;
    logic [1:0]         phase;
    logic signed [15:0] speed;

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         coil_reg;
    logic [1:0]         phase_out_reg;
    logic signed [15:0] speed_out_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !ctrl.fetch;

    spsp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_tick  (tick),
        .div_last (div_last),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    spsp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .div_last  (div_last),
        .phase     (phase),
        .speed     (speed)
    );

    // Hold the result until the transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            coil_reg      <= coil_of(phase);
            phase_out_reg <= phase;
            speed_out_reg <= speed;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coil_pattern = coil_reg;
    assign phase_index  = phase_out_reg;
    assign speed_now    = speed_out_reg;

    `SPSP_ASSERT(a_out_hold, out_valid_reg && out_stall |=> out_valid_reg, "stalled result dropped")
    `SPSP_NEVER(a_emit_overwrite, ctrl.emit && out_valid_reg && out_stall, "result overwritten while stalled")

endmodule

// File: hdl/spsp_div.sv
module spsp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        iter,
    input  logic [15:0] dividend,
    input  logic [14:0] divisor,
    output logic [15:0] quotient,
    output logic        last
);
    import spsp_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS);

    logic [15:0]      quo_reg, quo_next;
    logic [14:0]      rem_reg, rem_next;
    logic [14:0]      dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      trial;

    assign trial = {rem_reg, quo_reg[15]};

    // One restoring-division bit per iteration
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = '0;
        end
        else if (iter)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 15'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial[14:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == CNT_W'(DIV_BITS - 1));

endmodule

// File: hdl/spsp_dp.sv
`include "assert_macros.svh"

module spsp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  spsp_pkg::ctrl_t     ctrl,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                div_last,
    output logic [1:0]          phase,
    output logic signed [15:0]  speed
);
    import spsp_pkg::*;

    logic [15:0]        step_const_reg;
    logic [14:0]        speed_lim_reg;
    logic [7:0]         speed_step_reg;
    logic [16:0]        step_count_reg, step_count_next;
    logic [1:0]         phase_reg, phase_next;
    logic [9:0]         milli_reg, milli_next;
    logic [3:0]         second_reg, second_next;
    logic signed [15:0] speed_reg, speed_next;

    logic signed [16:0] speed_ext, sum, lim_pos, lim_neg, abs_speed;
    logic [9:0]         milli_inc;
    logic [15:0]        quotient;

    assign speed_ext = 17'(speed_reg);
    assign abs_speed = speed_reg[15] ? -speed_ext : speed_ext;
    assign lim_pos   = {2'b00, speed_lim_reg};
    assign lim_neg   = -lim_pos;
    assign milli_inc = milli_reg + 1'b1;

    spsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.load),
        .iter     (ctrl.iter),
        .dividend (step_const_reg),
        .divisor  (abs_speed[14:0]),
        .quotient (quotient),
        .last     (div_last)
    );

    // Speed after acceleration, before clamping
    always_comb
    begin
        case (accel_of(second_reg))
            ACC_PLUS:  sum = speed_ext + $signed({9'd0, speed_step_reg});
            ACC_MINUS: sum = speed_ext - $signed({9'd0, speed_step_reg});
            default:   sum = speed_ext;
        endcase
    end

    // Advance counters on load, commit step and speed afterwards
    always_comb
    begin
        step_count_next = step_count_reg;
        phase_next      = phase_reg;
        milli_next      = milli_reg;
        second_next     = second_reg;
        speed_next      = speed_reg;
        if (ctrl.load)
        begin
            if (step_count_reg != STEP_COUNT_MAX)
                step_count_next = step_count_reg + 1'b1;
            milli_next = milli_inc;
            if (milli_inc > MS_PER_SEC)
            begin
                milli_next  = milli_inc - MS_PER_SEC;
                second_next = (second_reg >= LAST_SECOND) ? 4'd0 : second_reg + 1'b1;
            end
        end
        if (ctrl.commit)
        begin
            if (speed_reg != 16'sd0 && step_count_reg > {1'b0, quotient})
            begin
                step_count_next = '0;
                phase_next      = speed_reg[15] ? phase_reg - 1'b1 : phase_reg + 1'b1;
            end
            if (sum > lim_pos)
                speed_next = lim_pos[15:0];
            else if (sum < lim_neg)
                speed_next = lim_neg[15:0];
            else
                speed_next = sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            phase_reg      <= '0;
            milli_reg      <= '0;
            second_reg     <= '0;
            speed_reg      <= 16'sd1;
        end
        else
        begin
            step_count_reg <= step_count_next;
            phase_reg      <= phase_next;
            milli_reg      <= milli_next;
            second_reg     <= second_next;
            speed_reg      <= speed_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_const_reg <= STEP_CONST_RST;
            speed_lim_reg  <= SPEED_LIM_RST;
            speed_step_reg <= SPEED_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_CONST: step_const_reg <= cfg_data;
                CFG_SPEED_LIM:  speed_lim_reg  <= cfg_data[14:0];
                CFG_SPEED_STEP: speed_step_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    assign phase = phase_reg;
    assign speed = speed_reg;

    `SPSP_ASSERT(a_no_step_at_rest, ctrl.commit && speed_reg == 16'sd0 |=> $stable(phase_reg), "phase moved at zero speed")
    `SPSP_NEVER(a_speed_range, speed_reg == 16'sh8000, "speed left its signed range")

endmodule

// File: hdl/spsp_seq.sv
`include "assert_macros.svh"

module spsp_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_tick,
    input  logic            div_last,
    input  logic            out_free,
    output spsp_pkg::ctrl_t ctrl
);
    import spsp_pkg::*;

    upc_t      upc_reg, upc_next;
    rom_word_t word;

    assign word = rom_word(upc_reg);

    // Branch on the current control word
    always_comb
    begin
        unique case (word.cond)
            COND_NEXT:
                upc_next = upc_reg + 1'b1;
            COND_FETCH:
                if (!in_valid)
                    upc_next = upc_reg;
                else if (!in_tick)
                    upc_next = word.target;
                else
                    upc_next = upc_reg + 1'b1;
            COND_LOOP_DIV:
                upc_next = div_last ? upc_reg + 1'b1 : upc_reg;
            COND_EMIT:
                upc_next = out_free ? word.target : upc_reg;
            default:
                upc_next = UPC_FETCH;
        endcase
    end

    // Drive the datapath, hold the output load until the slot is free
    always_comb
    begin
        ctrl      = word.ctrl;
        ctrl.emit = word.ctrl.emit && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_FETCH;
        else
            upc_reg <= upc_next;
    end

    `SPSP_ASSERT(a_div_exit, upc_reg == UPC_DIV && div_last |=> upc_reg == UPC_COMMIT, "divide loop did not exit")
    `SPSP_ASSERT(a_skip_idle, upc_reg == UPC_FETCH && in_valid && !in_tick |=> upc_reg == UPC_EMIT, "idle transfer did not go to emit")

endmodule

// File: tb/speed_profile_checker.sv
`timescale 1ns / 1ps

module speed_profile_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               tick,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         coil_pattern,
    input  logic [1:0]         phase_index,
    input  logic signed [15:0] speed_now,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 errors,
    output int                 pending,
    output int                 speed_lo,
    output int                 speed_hi
);
    import spsp_pkg::*;

    // One coil drive report as the block should present it
    typedef struct packed {
        logic [3:0]         coil;
        logic [1:0]         ph;
        logic signed [15:0] spd;
    } drive_state_t;

    drive_state_t due_drive_q[$];

    // Register copies
    logic [15:0] step_const;
    logic [14:0] speed_lim;
    logic [7:0]  speed_inc;

    // Motor and profile state
    logic [16:0] step_cnt;
    logic [1:0]  coil_phase;
    logic [9:0]  milli;
    logic [3:0]  sec;
    int          motor_speed;

    task automatic report(input string msg);
        errors++;
        if (errors <= 40)
            $display("chk: %0t: %s", $time, msg);
    endtask

    // Apply one transfer to the profile and return the drive state it reports
    task automatic advance_profile(input logic do_tick, output drive_state_t res);
        int     mag;
        int     thresh;
        int     next_ms;
        accel_t accel;
        if (do_tick)
        begin
            if (step_cnt != STEP_COUNT_MAX)
                step_cnt = step_cnt + 17'd1;
            // step on the speed from before this tick
            if (motor_speed != 0)
            begin
                mag = (motor_speed < 0) ? -motor_speed : motor_speed;
                thresh = int'(step_const) / mag;
                if (int'(step_cnt) > thresh)
                begin
                    step_cnt = '0;
                    if (motor_speed > 0)
                        coil_phase = coil_phase + 2'd1;
                    else
                        coil_phase = coil_phase - 2'd1;
                end
            end
            // advance milliseconds, roll into the twelve-second profile
            next_ms = int'(milli) + 1;
            if (next_ms > int'(MS_PER_SEC))
            begin
                sec = (sec >= LAST_SECOND) ? 4'd0 : sec + 4'd1;
                next_ms = next_ms % 1000;
            end
            milli = 10'(next_ms);
            // pick acceleration from the new second
            if (sec >= 4'd3 && sec <= 4'd5)
                accel = ACC_MINUS;
            else if (sec >= 4'd7 && sec <= 4'd9)
                accel = ACC_ZERO;
            else
                accel = ACC_PLUS;
            case (accel)
                ACC_PLUS:  motor_speed = motor_speed + int'(speed_inc);
                ACC_MINUS: motor_speed = motor_speed - int'(speed_inc);
                default:   ;
            endcase
            if (motor_speed > int'(speed_lim))
                motor_speed = int'(speed_lim);
            if (motor_speed < -int'(speed_lim))
                motor_speed = -int'(speed_lim);
        end
        case (coil_phase)
            2'd0:    res.coil = 4'b0011;
            2'd1:    res.coil = 4'b0110;
            2'd2:    res.coil = 4'b1100;
            default: res.coil = 4'b1001;
        endcase
        res.ph  = coil_phase;
        res.spd = 16'(motor_speed);
        if (motor_speed < speed_lo)
            speed_lo = motor_speed;
        if (motor_speed > speed_hi)
            speed_hi = motor_speed;
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        drive_state_t want;
        if (due_drive_q.size() == 0)
        begin
            report($sformatf("result with nothing expected: coil %b phase %0d speed %0d",
                             coil_pattern, phase_index, speed_now));
        end
        else
        begin
            want = due_drive_q.pop_front();
            if (coil_pattern !== want.coil)
                report($sformatf("coil_pattern got %b expected %b", coil_pattern, want.coil));
            if (phase_index !== want.ph)
                report($sformatf("phase_index got %0d expected %0d", phase_index, want.ph));
            if (speed_now !== want.spd)
                report($sformatf("speed_now got %0d expected %0d", speed_now, want.spd));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_state_t res;
        if (!rst_n)
        begin
            step_const  = STEP_CONST_RST;
            speed_lim   = SPEED_LIM_RST;
            speed_inc   = SPEED_STEP_RST;
            step_cnt    = '0;
            coil_phase  = '0;
            milli       = '0;
            sec         = '0;
            motor_speed = 1;
            speed_lo    = 1;
            speed_hi    = 1;
            errors      = 0;
            due_drive_q.delete();
            pending     = 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STEP_CONST: step_const = cfg_data;
                    CFG_SPEED_LIM:  speed_lim  = cfg_data[14:0];
                    CFG_SPEED_STEP: speed_inc  = cfg_data[7:0];
                    default:        ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
            begin
                advance_profile(tick, res);
                due_drive_q.push_back(res);
            end
            pending = due_drive_q.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import spsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_LEN       = 300;
    localparam int SEGMENTS       = 14;
    localparam int SEG_ITEMS      = 140;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               tick;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         coil_pattern;
    logic [1:0]         phase_index;
    logic signed [15:0] speed_now;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    int chk_errors;
    int chk_pending;
    int chk_speed_lo;
    int chk_speed_hi;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_reqs;
    int n_ticks;
    int n_reports;
    int n_writes;

    stepper_phase_speed_profile dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick         (tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coil_pattern (coil_pattern),
        .phase_index  (phase_index),
        .speed_now    (speed_now),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    speed_profile_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick         (tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coil_pattern (coil_pattern),
        .phase_index  (phase_index),
        .speed_now    (speed_now),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (chk_errors),
        .pending      (chk_pending),
        .speed_lo     (chk_speed_lo),
        .speed_hi     (chk_speed_hi)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random stall, or a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

    task automatic set_pacing(input int tx, input int rx);
        @(posedge clk);
        tx_idle_pct = tx;
        rx_stall_pct = rx;
    endtask

    // Offer one item and hold it until the transfer
    task automatic offer(input logic t);
        int gap;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(7) == 0)
            gap = $urandom_range(1, 24);
        @(negedge clk);
        while (gap > 0 || $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            tick <= 1'($urandom_range(1));
            if (gap > 0)
                gap--;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        tick <= t;
        do
            @(posedge clk);
        while (in_stall);
        if (t)
            n_ticks++;
        else
            n_reports++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        n_writes++;
    endtask

    task automatic ticks(input int count);
        repeat (count)
            offer(1'b1);
    endtask

    // Drain, then load a random register setting, extremes included
    task automatic pick_setting();
        logic [15:0] sc;
        logic [15:0] sl;
        logic [15:0] ss;
        case ($urandom_range(5))
            0:       sc = 16'd0;
            1:       sc = 16'hFFFF;
            2:       sc = 16'($urandom_range(1, 200));
            default: sc = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0:       sl = 16'h7FFF;
            1:       sl = 16'($urandom_range(0, 3));
            default: sl = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0:       ss = 16'd0;
            1:       ss = 16'h00FF;
            default: ss = 16'($urandom);
        endcase
        drain();
        cfg_write(CFG_STEP_CONST, sc);
        cfg_write(CFG_SPEED_LIM, sl);
        cfg_write(CFG_SPEED_STEP, ss);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        tick = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STEP_CONST;
        cfg_data = '0;
        hold_reqs = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        n_ticks = 0;
        n_reports = 0;
        n_writes = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset state, step on every tick, zero speed, widest settings
        offer(1'b0);
        ticks(3);
        drain();
        cfg_write(CFG_STEP_CONST, 16'd0);
        ticks(3);
        drain();
        cfg_write(CFG_SPEED_LIM, 16'd0);
        ticks(2);
        offer(1'b0);
        drain();
        cfg_write(CFG_SPEED_LIM, 16'h7FFF);
        cfg_write(CFG_SPEED_STEP, 16'd255);
        cfg_write(CFG_STEP_CONST, 16'hFFFF);
        ticks(4);
        offer(1'b0);
        drain();
        cfg_write(CFG_STEP_CONST, 16'd1);
        cfg_write(CFG_SPEED_STEP, 16'd0);
        ticks(3);
        offer(1'b0);
        drain();
        cfg_write(CFG_SPEED_LIM, 16'hFFFF);
        cfg_write(CFG_SPEED_STEP, 16'hFFFF);
        ticks(2);

        // Hold the result side off while items keep coming, then pause
        @(posedge clk);
        hold_reqs++;
        ticks(6);
        offer(1'b0);
        drain();

        // Random settings under each pacing, one more long hold-off midway
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            pick_setting();
            case (seg % 4)
                0:       set_pacing(0, 0);
                1:       set_pacing(48, 0);
                2:       set_pacing(0, 48);
                default: set_pacing(21, 21);
            endcase
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                offer($urandom_range(9) != 0);
                if (seg == 6 && i == 70)
                    hold_reqs++;
                if ($urandom_range(299) == 0)
                    drain();
            end
        end

        drain();
        repeat (25) @(posedge clk);
        $display("summary: %0d ticks and %0d report-only transfers, %0d register writes",
                 n_ticks, n_reports, n_writes);
        $display("summary: predicted speed ranged from %0d to %0d",
                 chk_speed_lo, chk_speed_hi);
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
